@@ rtl/open_address_hash_table_assert.svh @@
// assertion macros used by the port level checker of the hash table
// no dependencies; clock and reset are passed in by the caller
`ifndef OPEN_ADDRESS_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESS_HASH_TABLE_ASSERT_SVH

// property checked at every edge outside reset
`define OAHT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define OAHT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/oaht_pkg.sv @@
// shared constants, codes, types and helper functions of the hash table
// no dependencies; used by every module of the block but oaht_ram
`timescale 1ns / 1ps

package oaht_pkg;

  localparam int MAX_TABLE_BITS  = 10;
  localparam int MIN_TABLE_SLOTS = 4;
  localparam int MIN_TABLE_BITS  = $clog2(MIN_TABLE_SLOTS);
  localparam int DEPTH           = 1 << MAX_TABLE_BITS;
  localparam int SLOT_W          = MAX_TABLE_BITS;
  localparam int CNT_W           = MAX_TABLE_BITS + 1;
  localparam int BITS_W          = 4;
  localparam int WORD_W          = 32;
  localparam int POLY_W          = 17;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // response status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // slot state codes
  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_LIVE  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  typedef struct packed {
    op_t                op;
    logic [WORD_W-1:0]  key_word;
    logic [WORD_W-1:0]  data_word;
    logic [BITS_W-1:0]  bits;
    logic [SLOT_W-1:0]  start;
    logic [SLOT_W-1:0]  incr;
  } cmd_t;

  function automatic logic [BITS_W-1:0] eff_bits(input logic [BITS_W-1:0] tb);
    logic [BITS_W-1:0] b;
    b = tb;
    if (b > BITS_W'(MAX_TABLE_BITS)) b = BITS_W'(MAX_TABLE_BITS);
    if (b < BITS_W'(MIN_TABLE_BITS)) b = BITS_W'(MIN_TABLE_BITS);
    return b;
  endfunction

  // irreducible polynomial for each table size
  function automatic logic [POLY_W-1:0] gf_poly(input logic [BITS_W-1:0] b);
    logic [POLY_W-1:0] p;
    case (b)
      4'd2:    p = 17'd7;
      4'd3:    p = 17'd11;
      4'd4:    p = 17'd19;
      4'd5:    p = 17'd37;
      4'd6:    p = 17'd67;
      4'd7:    p = 17'd131;
      4'd8:    p = 17'd285;
      4'd9:    p = 17'd529;
      4'd10:   p = 17'd1033;
      4'd11:   p = 17'd2053;
      4'd12:   p = 17'd4179;
      4'd13:   p = 17'd8219;
      4'd14:   p = 17'd16427;
      4'd15:   p = 17'd32771;
      default: p = 17'd0;
    endcase
    return p;
  endfunction

endpackage

@@ rtl/oaht_if.sv @@
// request, response and configuration channel interfaces of the hash table
// depends on oaht_pkg
`timescale 1ns / 1ps

interface oaht_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 op;
  logic [oaht_pkg::WORD_W-1:0] key_word;
  logic [oaht_pkg::WORD_W-1:0] hash_word;
  logic [oaht_pkg::WORD_W-1:0] data_word;
  modport source (output valid, op, key_word, hash_word, data_word, input ready);
  modport sink (input valid, op, key_word, hash_word, data_word, output ready);
endinterface

interface oaht_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [oaht_pkg::WORD_W-1:0] read_data;
  logic [oaht_pkg::SLOT_W-1:0] slot_index;
  logic [oaht_pkg::CNT_W-1:0]  live_entries;
  modport source (output valid, status, read_data, slot_index, live_entries, input ready);
  modport sink (input valid, status, read_data, slot_index, live_entries, output ready);
endinterface

interface oaht_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [oaht_pkg::BITS_W-1:0] table_bits;
  modport source (output valid, table_bits, input ready);
  modport sink (input valid, table_bits, output ready);
endinterface

@@ rtl/oaht_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module oaht_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/oaht_front.sv @@
// front end: takes requests, derives probe start and step, holds one command
// depends on oaht_pkg and oaht_if
`timescale 1ns / 1ps

module oaht_front (
  input  logic                         clk,
  input  logic                         rst,
  oaht_req_if.sink                     req,
  input  logic [oaht_pkg::BITS_W-1:0]  table_bits,
  output logic                         cmd_valid,
  input  logic                         cmd_ready,
  output oaht_pkg::cmd_t               cmd
);

  logic                        vld;
  oaht_pkg::cmd_t              cmd_r;
  oaht_pkg::cmd_t              cmd_next;
  logic [oaht_pkg::BITS_W-1:0] bits;
  logic [oaht_pkg::CNT_W-1:0]  size;
  logic [oaht_pkg::SLOT_W-1:0] mask;
  logic [oaht_pkg::SLOT_W-1:0] mix;

  always_comb begin
    bits = oaht_pkg::eff_bits(table_bits);
    size = oaht_pkg::CNT_W'(1) << bits;
    mask = oaht_pkg::SLOT_W'(size - oaht_pkg::CNT_W'(1));
    mix  = (req.hash_word[oaht_pkg::SLOT_W-1:0] ^ req.hash_word[oaht_pkg::SLOT_W+2:3]) & mask;
    cmd_next.op        = oaht_pkg::op_t'(req.op);
    cmd_next.key_word  = req.key_word;
    cmd_next.data_word = req.data_word;
    cmd_next.bits      = bits;
    cmd_next.start     = ~req.hash_word[oaht_pkg::SLOT_W-1:0] & mask;
    cmd_next.incr      = (mix == '0) ? mask : mix;
  end

  assign req.ready = !vld || cmd_ready;
  assign cmd_valid = vld;
  assign cmd       = cmd_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (req.valid && req.ready) begin
      vld <= 1'b1;
    end else if (cmd_ready) begin
      vld <= 1'b0;
    end
    if (req.valid && req.ready) cmd_r <= cmd_next;
  end

endmodule

@@ rtl/oaht_queue.sv @@
// short command queue between the front end and the probe engine
// depends on oaht_pkg
`timescale 1ns / 1ps

module oaht_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  oaht_pkg::cmd_t in_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output oaht_pkg::cmd_t out_cmd
);

  oaht_pkg::cmd_t              entries [oaht_pkg::QUEUE_DEPTH];
  logic [oaht_pkg::QPTR_W-1:0] wr_ptr;
  logic [oaht_pkg::QPTR_W-1:0] rd_ptr;
  logic [oaht_pkg::QCNT_W-1:0] count;
  logic                        push;
  logic                        pop;

  assign in_ready  = count != oaht_pkg::QCNT_W'(oaht_pkg::QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_cmd   = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == oaht_pkg::QPTR_W'(oaht_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == oaht_pkg::QPTR_W'(oaht_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
    if (push) entries[wr_ptr] <= in_cmd;
  end

endmodule

@@ rtl/oaht_back.sv @@
// probe engine: slot memories, counts, clearing sweep and response register
// depends on oaht_pkg, oaht_if and oaht_ram
`timescale 1ns / 1ps

module oaht_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_clear,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  oaht_pkg::cmd_t cmd,
  oaht_rsp_if.source     rsp
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_CHECK = 6'b001000,
    S_ACT   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  localparam int SW = oaht_pkg::SLOT_W;
  localparam int CW = oaht_pkg::CNT_W;
  localparam int WW = oaht_pkg::WORD_W;

  state_t         state;
  oaht_pkg::cmd_t cmd_r;
  logic [SW-1:0]  idx;
  logic [SW-1:0]  incr;
  logic [CW-1:0]  n;
  logic           have_free;
  logic [SW-1:0]  free_slot;
  logic [SW-1:0]  slot_r;
  logic           found;
  logic           placeable;
  logic           place_empty;
  logic [SW-1:0]  clr_cnt;
  logic           clear_after;
  logic [CW-1:0]  filled;
  logic [CW-1:0]  live;
  logic [1:0]     res_status;
  logic [SW-1:0]  res_slot;
  logic [CW-1:0]  res_live;

  logic           out_valid;
  logic [1:0]     out_status;
  logic [WW-1:0]  out_data;
  logic [SW-1:0]  out_slot;
  logic [CW-1:0]  out_live;

  logic [1:0]     st_rd;
  logic [WW-1:0]  key_rd;
  logic [WW-1:0]  val_rd;

  logic [CW-1:0]  size;
  logic [SW-1:0]  mask;
  logic [oaht_pkg::POLY_W-1:0] poly;
  logic [SW:0]    incr_sh;
  logic [SW-1:0]  incr_nx;
  logic [SW-1:0]  idx_nx;
  logic           last;
  logic           key_hit;
  logic [CW+1:0]  filled_x3;
  logic           full;

  logic           st_we;
  logic [1:0]     st_wdata;
  logic           key_we;
  logic           val_we;
  logic [1:0]     act_status;
  logic [SW-1:0]  act_slot;
  logic [CW-1:0]  filled_next;
  logic [CW-1:0]  live_next;
  logic           out_free;

  always_comb begin
    size      = CW'(1) << cmd_r.bits;
    mask      = SW'(size - CW'(1));
    poly      = oaht_pkg::gf_poly(cmd_r.bits);
    incr_sh   = {incr, 1'b0};
    incr_nx   = (incr_sh > {1'b0, mask}) ? SW'(incr_sh ^ poly[SW:0]) : SW'(incr_sh);
    idx_nx    = SW'(cmd_r.start + incr) & mask;
    last      = (n + CW'(1)) == size;
    key_hit   = (st_rd == oaht_pkg::SLOT_LIVE) && (key_rd == cmd_r.key_word);
    filled_x3 = {1'b0, filled, 1'b0} + (CW+2)'(filled);
    full      = filled_x3 >= (CW+2)'({size, 1'b0});
  end

  // decide the update for the resolved probe
  always_comb begin
    st_we       = 1'b0;
    st_wdata    = oaht_pkg::SLOT_LIVE;
    key_we      = 1'b0;
    val_we      = 1'b0;
    act_status  = oaht_pkg::ST_OK;
    act_slot    = '0;
    filled_next = filled;
    live_next   = live;
    case (cmd_r.op)
      oaht_pkg::OP_LOOKUP: begin
        if (found) act_slot = slot_r;
        else act_status = oaht_pkg::ST_NOT_FOUND;
      end
      oaht_pkg::OP_INSERT: begin
        if (found) begin
          val_we   = 1'b1;
          act_slot = slot_r;
        end else if (full || !placeable) begin
          act_status = oaht_pkg::ST_FULL;
        end else begin
          st_we       = 1'b1;
          key_we      = 1'b1;
          val_we      = 1'b1;
          filled_next = filled + CW'(place_empty);
          live_next   = live + CW'(1);
          act_slot    = slot_r;
        end
      end
      oaht_pkg::OP_DELETE: begin
        if (found) begin
          st_we     = 1'b1;
          st_wdata  = oaht_pkg::SLOT_TOMB;
          live_next = (live != '0) ? live - CW'(1) : live;
          act_slot  = slot_r;
        end else begin
          act_status = oaht_pkg::ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    if (state != S_ACT) begin
      st_we  = 1'b0;
      key_we = 1'b0;
      val_we = 1'b0;
    end
  end

  oaht_ram #(.WIDTH(2), .DEPTH(oaht_pkg::DEPTH)) u_status_ram (
    .clk   (clk),
    .we    (state == S_CLEAR || st_we),
    .waddr ((state == S_CLEAR) ? clr_cnt : slot_r),
    .wdata ((state == S_CLEAR) ? oaht_pkg::SLOT_EMPTY : st_wdata),
    .raddr (idx),
    .rdata (st_rd)
  );

  oaht_ram #(.WIDTH(WW), .DEPTH(oaht_pkg::DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (slot_r),
    .wdata (cmd_r.key_word),
    .raddr (idx),
    .rdata (key_rd)
  );

  oaht_ram #(.WIDTH(WW), .DEPTH(oaht_pkg::DEPTH)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (slot_r),
    .wdata (cmd_r.data_word),
    .raddr (slot_r),
    .rdata (val_rd)
  );

  assign cmd_ready        = state == S_IDLE;
  assign out_free         = !out_valid || rsp.ready;
  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.read_data    = out_data;
  assign rsp.slot_index   = out_slot;
  assign rsp.live_entries = out_live;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      filled    <= '0;
      live      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free && !cfg_clear) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
      if (cfg_clear) begin
        state   <= S_CLEAR;
        clr_cnt <= '0;
        filled  <= '0;
        live    <= '0;
      end else begin
        case (state)
          S_CLEAR: begin
            clr_cnt <= clr_cnt + 1'b1;
            if (clr_cnt == SW'(oaht_pkg::DEPTH - 1)) state <= S_IDLE;
          end
          S_IDLE: begin
            if (cmd_valid) begin
              cmd_r     <= cmd;
              idx       <= cmd.start;
              incr      <= cmd.incr;
              n         <= '0;
              have_free <= 1'b0;
              if (cmd.op == oaht_pkg::OP_CLEAR) begin
                filled      <= '0;
                live        <= '0;
                res_status  <= oaht_pkg::ST_OK;
                res_slot    <= '0;
                res_live    <= '0;
                clear_after <= 1'b1;
                state       <= S_DONE;
              end else begin
                clear_after <= 1'b0;
                state       <= S_READ;
              end
            end
          end
          S_READ: state <= S_CHECK;
          S_CHECK: begin
            if (st_rd == oaht_pkg::SLOT_EMPTY) begin
              found       <= 1'b0;
              placeable   <= 1'b1;
              place_empty <= !have_free;
              slot_r      <= have_free ? free_slot : idx;
              state       <= S_ACT;
            end else if (key_hit) begin
              found  <= 1'b1;
              slot_r <= idx;
              state  <= S_ACT;
            end else if (last) begin
              // whole table visited without an empty slot
              found       <= 1'b0;
              placeable   <= have_free || (st_rd == oaht_pkg::SLOT_TOMB);
              place_empty <= 1'b0;
              slot_r      <= have_free ? free_slot : idx;
              state       <= S_ACT;
            end else begin
              if (st_rd == oaht_pkg::SLOT_TOMB && !have_free) begin
                have_free <= 1'b1;
                free_slot <= idx;
              end
              idx   <= idx_nx;
              incr  <= incr_nx;
              n     <= n + CW'(1);
              state <= S_READ;
            end
          end
          S_ACT: begin
            filled     <= filled_next;
            live       <= live_next;
            res_status <= act_status;
            res_slot   <= act_slot;
            res_live   <= live_next;
            state      <= S_DONE;
          end
          S_DONE: begin
            if (out_free) begin
              state   <= clear_after ? S_CLEAR : S_IDLE;
              clr_cnt <= '0;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
    if (state == S_DONE && out_free) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_live   <= res_live;
      out_data   <= (cmd_r.op == oaht_pkg::OP_LOOKUP && res_status == oaht_pkg::ST_OK)
                    ? val_rd : '0;
    end
  end

endmodule

@@ rtl/open_address_hash_table.sv @@
// Open-addressed key/value hash table with tombstones. Requests (lookup,
// insert, delete, clear) enter a front stage and a two-entry queue, so new
// requests are taken while the probe engine works and a response waits.
// The probe engine reads one slot at a time, each in two steps (status and
// key memory read, then compare), and visits between one slot and the whole
// table on a request; a response is delayed while the response register is
// held. A clear request answers before its sweep. After reset, after a clear
// request and after any write of table_bits, the engine sweeps all 1024 slot
// states to empty, during which no request is processed. table_bits is
// clamped to 2..10 and writing it also empties the table.
// depends on oaht_pkg, oaht_if, oaht_front, oaht_queue, oaht_back
`timescale 1ns / 1ps

module open_address_hash_table (
  input  logic       clk,
  input  logic       rst,
  oaht_req_if.sink   req,
  oaht_rsp_if.source rsp,
  oaht_cfg_if.sink   cfg
);

  logic [oaht_pkg::BITS_W-1:0] table_bits;
  logic                        cfg_clear;
  logic                        f_valid;
  logic                        f_ready;
  oaht_pkg::cmd_t              f_cmd;
  logic                        q_valid;
  logic                        q_ready;
  oaht_pkg::cmd_t              q_cmd;

  assign cfg.ready = 1'b1;
  assign cfg_clear = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_bits <= oaht_pkg::BITS_W'(oaht_pkg::MAX_TABLE_BITS);
    end else if (cfg_clear) begin
      table_bits <= cfg.table_bits;
    end
  end

  oaht_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .table_bits (table_bits),
    .cmd_valid  (f_valid),
    .cmd_ready  (f_ready),
    .cmd        (f_cmd)
  );

  oaht_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_cmd    (f_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_cmd   (q_cmd)
  );

  oaht_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_clear (cfg_clear),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .rsp       (rsp)
  );

endmodule

@@ rtl/oaht_chk.sv @@
// port level checker of the hash table, bound to the top level
// depends on oaht_pkg and open_address_hash_table_assert.svh
`timescale 1ns / 1ps
`include "open_address_hash_table_assert.svh"

module oaht_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [1:0]                  rsp_status,
  input logic [oaht_pkg::WORD_W-1:0] rsp_read_data,
  input logic [oaht_pkg::SLOT_W-1:0] rsp_slot_index,
  input logic [oaht_pkg::CNT_W-1:0]  rsp_live_entries
);

  `OAHT_ASSERT_ALWAYS(a_no_rsp_after_rst, clk, rst |=> !rsp_valid, "response after reset")
  `OAHT_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data), "response dropped or changed while stalled")
  `OAHT_ASSERT(a_miss_no_data, clk, rst, rsp_valid && rsp_status != oaht_pkg::ST_OK |-> rsp_read_data == '0 && rsp_slot_index == '0, "failed request carries data or slot")
  `OAHT_ASSERT(a_live_bound, clk, rst, rsp_valid |-> rsp_live_entries <= oaht_pkg::CNT_W'(oaht_pkg::DEPTH), "live count above table depth")

endmodule

bind open_address_hash_table oaht_chk u_oaht_chk (
  .clk              (clk),
  .rst              (rst),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_read_data    (rsp.read_data),
  .rsp_slot_index   (rsp.slot_index),
  .rsp_live_entries (rsp.live_entries)
);

@@ sim/oaht_checker.sv @@
// scoreboard for the open-addressed hash table: watches the request, response and
// configuration channels, predicts every response and compares it field by field
// depends on oaht_pkg and oaht_if
`timescale 1ns / 1ps

module oaht_checker (
  input  logic clk,
  input  logic rst,
  oaht_req_if  req,
  oaht_rsp_if  rsp,
  oaht_cfg_if  cfg,
  output int   errors,
  output int   pending
);
  import oaht_pkg::*;

  typedef struct {
    logic [1:0]        status;
    logic [WORD_W-1:0] read_data;
    logic [SLOT_W-1:0] slot_index;
    logic [CNT_W-1:0]  live_entries;
  } answer_t;

  logic [WORD_W-1:0] tbl_key [DEPTH];
  logic [WORD_W-1:0] tbl_val [DEPTH];
  logic [1:0]        tbl_state [DEPTH];
  int                filled;
  int                live;
  logic [BITS_W-1:0] size_bits;
  answer_t           answer_q[$];

  function automatic int clamp_bits(input logic [BITS_W-1:0] b);
    if (b > MAX_TABLE_BITS) return MAX_TABLE_BITS;
    if (b < 2) return 2;
    return b;
  endfunction

  function automatic int field_poly(input int b);
    case (b)
      2: return 7;
      3: return 11;
      4: return 19;
      5: return 37;
      6: return 67;
      7: return 131;
      8: return 285;
      9: return 529;
      default: return 1033;
    endcase
  endfunction

  function automatic void empty_table();
    for (int i = 0; i < DEPTH; i++) tbl_state[i] = SLOT_EMPTY;
    filled = 0;
    live = 0;
  endfunction

  // returns 1 found, 2 place, 0 none
  function automatic int find_slot(input logic [31:0] key, input logic [31:0] hash,
                                   output int slot);
    int b, size, mask, poly, start, step, idx;
    bit have_free;
    int free_slot;
    b = clamp_bits(size_bits);
    size = 1 << b;
    mask = size - 1;
    poly = field_poly(b);
    start = int'(~hash) & mask;
    step = int'(hash ^ (hash >> 3)) & mask;
    have_free = 0;
    free_slot = 0;
    slot = 0;
    if (step == 0) step = mask;
    for (int n = 0; n < size; n++) begin
      if (n == 0) idx = start;
      else begin
        idx = (start + step) & mask;
        step = step << 1;
        if (step > mask) step = step ^ poly;
      end
      if (tbl_state[idx] == SLOT_EMPTY) begin
        slot = have_free ? free_slot : idx;
        return 2;
      end
      if (tbl_state[idx] == SLOT_LIVE) begin
        if (tbl_key[idx] == key) begin
          slot = idx;
          return 1;
        end
      end else if (!have_free) begin
        have_free = 1;
        free_slot = idx;
      end
    end
    slot = free_slot;
    return have_free ? 2 : 0;
  endfunction

  function automatic answer_t apply_request(input op_t op, input logic [31:0] key,
                                            input logic [31:0] hash, input logic [31:0] data);
    answer_t a;
    int r, s, size;
    a.status = ST_OK;
    a.read_data = '0;
    a.slot_index = '0;
    if (op == OP_CLEAR) empty_table();
    else begin
      r = find_slot(key, hash, s);
      size = 1 << clamp_bits(size_bits);
      case (op)
        OP_LOOKUP: begin
          if (r == 1) begin
            a.read_data = tbl_val[s];
            a.slot_index = SLOT_W'(s);
          end else a.status = ST_NOT_FOUND;
        end
        OP_INSERT: begin
          if (r == 1) begin
            tbl_val[s] = data;
            a.slot_index = SLOT_W'(s);
          end else if (filled * 3 >= size * 2 || r == 0) a.status = ST_FULL;
          else begin
            if (tbl_state[s] == SLOT_EMPTY) filled++;
            tbl_state[s] = SLOT_LIVE;
            tbl_key[s] = key;
            tbl_val[s] = data;
            live++;
            a.slot_index = SLOT_W'(s);
          end
        end
        default: begin
          if (r == 1) begin
            tbl_state[s] = SLOT_TOMB;
            if (live > 0) live--;
            a.slot_index = SLOT_W'(s);
          end else a.status = ST_NOT_FOUND;
        end
      endcase
    end
    a.live_entries = CNT_W'(live);
    return a;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      size_bits = 4'd10;
      empty_table();
      answer_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        size_bits = cfg.table_bits;
        empty_table();
      end
      if (req.valid && req.ready)
        answer_q.push_back(apply_request(op_t'(req.op), req.key_word, req.hash_word,
                                         req.data_word));
      if (rsp.valid && rsp.ready) begin
        if (answer_q.size() == 0) begin
          report("unexpected response", 32'(rsp.status), 32'(0));
        end else begin
          want = answer_q.pop_front();
          if (rsp.status !== want.status)
            report("status", 32'(rsp.status), 32'(want.status));
          if (rsp.read_data !== want.read_data)
            report("read_data", rsp.read_data, want.read_data);
          if (rsp.slot_index !== want.slot_index)
            report("slot_index", 32'(rsp.slot_index), 32'(want.slot_index));
          if (rsp.live_entries !== want.live_entries)
            report("live_entries", 32'(rsp.live_entries), 32'(want.live_entries));
        end
      end
    end
    pending = answer_q.size();
  end

endmodule

@@ sim/open_address_hash_table_test.sv @@
// top of the hash table testbench: clock, reset, request and configuration stimulus,
// response back-pressure and the verdict; depends on oaht_pkg, oaht_if, oaht_checker
`timescale 1ns / 1ps

module open_address_hash_table_test;
  import oaht_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors, pending;
  int   snd_pct = 0, rcv_pct = 0;
  bit   stall_req = 0;
  int   stall_cnt = 0;
  longint cycles = 0;

  logic [31:0] pool_key [40];
  logic [31:0] pool_hash [40];

  oaht_req_if req ();
  oaht_rsp_if rsp ();
  oaht_cfg_if cfg ();

  open_address_hash_table uut (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));
  oaht_checker chk (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg),
                    .errors(errors), .pending(pending));

  always #4 clk = ~clk;

  initial begin
    req.valid = 1'b0;
    req.op = OP_LOOKUP;
    req.key_word = '0;
    req.hash_word = '0;
    req.data_word = '0;
    cfg.valid = 1'b0;
    cfg.table_bits = '0;
    rsp.ready = 1'b0;
  end

  // receiver back-pressure, with one long hold-off on request
  always @(posedge clk) begin
    if (stall_req && stall_cnt < 400) begin
      rsp.ready <= 1'b0;
      stall_cnt <= stall_cnt + 1;
    end else rsp.ready <= ($urandom_range(99) >= rcv_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 40000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send(input op_t op, input logic [31:0] key, input logic [31:0] hash,
                      input logic [31:0] data);
    while ($urandom_range(99) < snd_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op <= op;
    req.key_word <= key;
    req.hash_word <= hash;
    req.data_word <= data;
    do @(posedge clk); while (!req.ready);
  endtask

  // table size change only once the table has drained
  task automatic set_size(input logic [3:0] b);
    req.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.table_bits <= b;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  task automatic pool_request();
    int i, pick;
    logic [31:0] hash;
    op_t op;
    i = $urandom_range(39);
    hash = ($urandom_range(9) == 0) ? $urandom : pool_hash[i];
    pick = $urandom_range(199);
    if (pick < 80) op = OP_INSERT;
    else if (pick < 140) op = OP_LOOKUP;
    else if (pick < 198) op = OP_DELETE;
    else op = OP_CLEAR;
    if ($urandom_range(19) == 0) send(op, $urandom, $urandom, $urandom);
    else send(op, pool_key[i], hash, $urandom);
  endtask

  initial begin
    logic [3:0] sizes [9] = '{4'd3, 4'd15, 4'd5, 4'd0, 4'd10, 4'd4, 4'd8, 4'd2, 4'd9};
    int n;
    n = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // small table: threshold, tombstones, misses and extremes
    set_size(4'd2);
    send(OP_INSERT, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF);
    send(OP_INSERT, 32'h0000_0002, 32'hFFFF_FFFF, 32'h0000_0000);
    send(OP_INSERT, 32'h0000_0003, 32'h1234_5678, 32'h5555_5555);
    send(OP_INSERT, 32'h0000_0001, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
    send(OP_LOOKUP, 32'h0000_0001, 32'h0000_0000, 32'h0);
    send(OP_LOOKUP, 32'h0000_0003, 32'h1234_5678, 32'h0);
    send(OP_DELETE, 32'h0000_0002, 32'hFFFF_FFFF, 32'h0);
    send(OP_DELETE, 32'h0000_0002, 32'hFFFF_FFFF, 32'h0);
    send(OP_INSERT, 32'h0000_0003, 32'h1234_5678, 32'h5555_5555);
    send(OP_LOOKUP, 32'h0000_0003, 32'h1234_5678, 32'h0);
    send(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0008, 32'h0);
    send(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(OP_LOOKUP, 32'h0000_0001, 32'h0000_0000, 32'h0);
    send(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 32'h1);
    send(OP_DELETE, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0);
    send(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0);

    for (int p = 0; p < 9; p++) begin
      set_size(sizes[p]);
      for (int i = 0; i < 40; i++) begin
        pool_key[i] = $urandom;
        pool_hash[i] = $urandom;
      end
      if (p == 2) stall_req = 1;
      for (int k = 0; k < 210; k++) begin
        if (n < 630) begin
          snd_pct = 27;
          rcv_pct = 62;
        end else if (n < 1260) begin
          snd_pct = 62;
          rcv_pct = 27;
        end else begin
          snd_pct = 0;
          rcv_pct = 0;
        end
        if (p == 4 && k == 100) begin
          req.valid <= 1'b0;
          @(posedge clk);
          wait (pending == 0);
          @(posedge clk);
        end
        pool_request();
        n++;
      end
    end
    req.valid <= 1'b0;
    rcv_pct = 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
